// ===== rtl/dppt_pkg.sv =====
// Shared types and constants for the dual pedal plausibility and torque block.
// No dependencies; every other file of the block imports this package.
package dppt_pkg;

	localparam int SAMPLE_W = 12;
	localparam int PCT_W    = 7;
	localparam int TORQUE_W = 6;
	localparam int MOTOR_W  = 10;
	localparam int COUNT_W  = 8;
	localparam int CFG_IDX_W = 4;

	// (sample - start) * 100 fits in 19 bits; one quotient bit per step
	localparam int NUM_W     = 19;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W    = 5;

	localparam logic [PCT_W-1:0]   PCT_FULL       = 7'd100;
	localparam logic [PCT_W-1:0]   MISMATCH_LIMIT = 7'd10;
	localparam logic [COUNT_W-1:0] STOP_LIMIT     = 8'd20;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;

	// mean * 60 / 100 as mean * TORQUE_MUL >> 19, TORQUE_MUL just above 0.6 * 2^19
	localparam int                 TORQUE_SHIFT = 19;
	localparam logic [18:0]        TORQUE_MUL   = 19'd314580;
	// torque * 100 / 60 as torque * TPCT_MUL >> 17, TPCT_MUL just above 5/3 * 2^17
	localparam int                 TPCT_SHIFT   = 17;
	localparam logic [17:0]        TPCT_MUL     = 18'd218455;
	localparam logic [3:0]         MOTOR_MUL    = 4'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P1_UPPER = 4'd0,
		REG_P1_LOWER = 4'd1,
		REG_P2_UPPER = 4'd2,
		REG_P2_LOWER = 4'd3,
		REG_P1_START = 4'd4,
		REG_P1_SPAN  = 4'd5,
		REG_P2_START = 4'd6,
		REG_P2_SPAN  = 4'd7
	} cfg_reg_e;

	typedef struct packed {
		logic [SAMPLE_W-1:0] upper;
		logic [SAMPLE_W-1:0] lower;
		logic [SAMPLE_W-1:0] start;
		logic [SAMPLE_W-1:0] span;
	} lane_cfg_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic             bad;
		logic [PCT_W-1:0] percent;
	} lane_res_t;

endpackage

// ===== rtl/dppt_ifs.sv =====
// Handshake channel interfaces: pedal samples in, torque result out, register writes.
// Depends on dppt_pkg for field widths.
interface dppt_in_if import dppt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] pedal1_sample;
	logic [SAMPLE_W-1:0] pedal2_sample;

	modport source (output valid, pedal1_sample, pedal2_sample, input ready);
	modport sink   (input valid, pedal1_sample, pedal2_sample, output ready);
endinterface

interface dppt_out_if import dppt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PCT_W-1:0]    pedal1_percent;
	logic [PCT_W-1:0]    pedal2_percent;
	logic [TORQUE_W-1:0] torque_value;
	logic [PCT_W-1:0]    torque_percent;
	logic [MOTOR_W-1:0]  motor_command;
	logic [COUNT_W-1:0]  range_error_count;
	logic [COUNT_W-1:0]  mismatch_count;
	logic                stop_flag;

	modport source (output valid, pedal1_percent, pedal2_percent, torque_value,
		torque_percent, motor_command, range_error_count, mismatch_count, stop_flag,
		input ready);
	modport sink   (input valid, pedal1_percent, pedal2_percent, torque_value,
		torque_percent, motor_command, range_error_count, mismatch_count, stop_flag,
		output ready);
endinterface

interface dppt_cfg_if import dppt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SAMPLE_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dppt_lane.sv =====
// One sensor lane: window check and travel percent by a bit-serial restoring divider.
// Depends on dppt_pkg.
module dppt_lane import dppt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SAMPLE_W-1:0] sample,
	input  lane_cfg_t           cfg,
	output lane_res_t           res
);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [NUM_W-1:0]    num_q;
	logic [SAMPLE_W-1:0] span_q;
	logic                below_q;
	logic                zspan_q;
	logic                bad_q;

	logic [SAMPLE_W-1:0] delta;
	logic [NUM_W-1:0]    scaled;
	logic [SAMPLE_W:0]   trial;
	logic                ge;
	logic [SAMPLE_W:0]   trial_sub;

	always_comb begin
		delta     = (sample >= cfg.start) ? sample - cfg.start : '0;
		scaled    = NUM_W'(delta) * NUM_W'(PCT_FULL);
		trial     = {rem_q, num_q[NUM_W-1]};
		ge        = trial >= {1'b0, span_q};
		trial_sub = trial - {1'b0, span_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			num_q   <= scaled;
			span_q  <= cfg.span;
			below_q <= sample < cfg.start;
			zspan_q <= cfg.span == '0;
			bad_q   <= (sample > cfg.upper) || (sample < cfg.lower);
		end else if (busy_q) begin
			// shift in one quotient bit per cycle
			rem_q <= ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	always_comb begin
		res.busy = busy_q;
		res.done = done_q;
		res.bad  = bad_q;
		priority if (below_q)
			res.percent = '0;
		else if (zspan_q || num_q > NUM_W'(PCT_FULL))
			res.percent = PCT_FULL;
		else
			res.percent = num_q[PCT_W-1:0];
	end

endmodule

// ===== rtl/dppt_merge.sv =====
// Merging stage: fault counters, stop latch, torque scaling and the output register.
// Depends on dppt_pkg and the output channel interface.
module dppt_merge import dppt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lane_res_t        lane1,
	input  lane_res_t        lane2,
	output logic             s1_busy,
	dppt_out_if.source       out_ch
);

	logic [COUNT_W-1:0]  rng_q;
	logic [COUNT_W-1:0]  mis_q;
	logic                stop_q;

	logic [COUNT_W-1:0]  rng_next;
	logic [COUNT_W-1:0]  mis_next;
	logic                stop_next;
	logic [PCT_W-1:0]    diff;
	logic [PCT_W:0]      sum;
	logic [PCT_W-1:0]    mean;
	logic [25:0]         torque_prod;

	logic                valid_s1;
	logic [PCT_W-1:0]    p1_s1;
	logic [PCT_W-1:0]    p2_s1;
	logic [TORQUE_W-1:0] torque_s1;
	logic [COUNT_W-1:0]  rng_s1;
	logic [COUNT_W-1:0]  mis_s1;
	logic                stop_s1;

	logic [23:0]         tpct_prod;
	logic [MOTOR_W-1:0]  motor;
	logic                load_out;

	logic                valid_q;
	logic [PCT_W-1:0]    p1_q;
	logic [PCT_W-1:0]    p2_q;
	logic [TORQUE_W-1:0] torque_q;
	logic [PCT_W-1:0]    tpct_q;
	logic [MOTOR_W-1:0]  motor_q;
	logic [COUNT_W-1:0]  rng_out_q;
	logic [COUNT_W-1:0]  mis_out_q;
	logic                stop_out_q;

	always_comb begin
		diff = (lane1.percent >= lane2.percent) ? lane1.percent - lane2.percent
		                                        : lane2.percent - lane1.percent;
		if (lane1.bad || lane2.bad)
			rng_next = (rng_q == COUNT_MAX) ? rng_q : rng_q + 1'b1;
		else
			rng_next = '0;
		if (diff > MISMATCH_LIMIT)
			mis_next = (mis_q == COUNT_MAX) ? mis_q : mis_q + 1'b1;
		else
			mis_next = '0;
		stop_next   = stop_q || rng_next >= STOP_LIMIT || mis_next >= STOP_LIMIT;
		sum         = {1'b0, lane1.percent} + {1'b0, lane2.percent};
		mean        = sum[PCT_W:1];
		torque_prod = 26'(mean) * 26'(TORQUE_MUL);
		tpct_prod   = 24'(torque_s1) * 24'(TPCT_MUL);
		motor       = MOTOR_W'(torque_s1) * MOTOR_W'(MOTOR_MUL);
		load_out    = valid_s1 && (!valid_q || out_ch.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q    <= '0;
			mis_q    <= '0;
			stop_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (lane1.done) begin
				rng_q    <= rng_next;
				mis_q    <= mis_next;
				stop_q   <= stop_next;
				valid_s1 <= 1'b1;
			end else if (load_out) begin
				valid_s1 <= 1'b0;
			end
			if (load_out)
				valid_q <= 1'b1;
			else if (out_ch.ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lane1.done) begin
			p1_s1     <= lane1.percent;
			p2_s1     <= lane2.percent;
			torque_s1 <= torque_prod[TORQUE_SHIFT+TORQUE_W-1:TORQUE_SHIFT];
			rng_s1    <= rng_next;
			mis_s1    <= mis_next;
			stop_s1   <= stop_next;
		end
		if (load_out) begin
			p1_q       <= p1_s1;
			p2_q       <= p2_s1;
			torque_q   <= torque_s1;
			tpct_q     <= tpct_prod[TPCT_SHIFT+PCT_W-1:TPCT_SHIFT];
			motor_q    <= motor;
			rng_out_q  <= rng_s1;
			mis_out_q  <= mis_s1;
			stop_out_q <= stop_s1;
		end
	end

	assign s1_busy                  = valid_s1;
	assign out_ch.valid             = valid_q;
	assign out_ch.pedal1_percent    = p1_q;
	assign out_ch.pedal2_percent    = p2_q;
	assign out_ch.torque_value      = torque_q;
	assign out_ch.torque_percent    = tpct_q;
	assign out_ch.motor_command     = motor_q;
	assign out_ch.range_error_count = rng_out_q;
	assign out_ch.mismatch_count    = mis_out_q;
	assign out_ch.stop_flag         = stop_out_q;

endmodule

// ===== rtl/dual_pedal_plausibility_torque.sv =====
// Dual pedal plausibility check and torque request, top level.
// An accepted item runs through the lane dividers, then the merge stage register, then the output register.
// The two lane dividers retire one quotient bit a cycle over 19 steps, and a new item is not taken
// before the previous one has left the lanes and the merge stage has drained.
// Reset: arst_n clears counters, stop latch and handshake state and loads register defaults.
// Depends on dppt_pkg, dppt_ifs, dppt_lane and dppt_merge.
module dual_pedal_plausibility_torque import dppt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dppt_in_if.sink   in_ch,
	dppt_out_if.source out_ch,
	dppt_cfg_if.sink  cfg
);

	lane_cfg_t lane1_cfg_q;
	lane_cfg_t lane2_cfg_q;
	lane_res_t lane1_res;
	lane_res_t lane2_res;
	logic      s1_busy;
	logic      accept;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !lane1_res.busy && !lane1_res.done && !s1_busy;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane1_cfg_q <= '{upper: 12'd4095, lower: 12'd0, start: 12'd0, span: 12'd4095};
			lane2_cfg_q <= '{upper: 12'd4095, lower: 12'd0, start: 12'd0, span: 12'd4095};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_P1_UPPER: lane1_cfg_q.upper <= cfg.data;
				REG_P1_LOWER: lane1_cfg_q.lower <= cfg.data;
				REG_P2_UPPER: lane2_cfg_q.upper <= cfg.data;
				REG_P2_LOWER: lane2_cfg_q.lower <= cfg.data;
				REG_P1_START: lane1_cfg_q.start <= cfg.data;
				REG_P1_SPAN:  lane1_cfg_q.span  <= cfg.data;
				REG_P2_START: lane2_cfg_q.start <= cfg.data;
				REG_P2_SPAN:  lane2_cfg_q.span  <= cfg.data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	dppt_lane u_lane1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.sample (in_ch.pedal1_sample),
		.cfg    (lane1_cfg_q),
		.res    (lane1_res)
	);

	dppt_lane u_lane2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.sample (in_ch.pedal2_sample),
		.cfg    (lane2_cfg_q),
		.res    (lane2_res)
	);

	dppt_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.lane1   (lane1_res),
		.lane2   (lane2_res),
		.s1_busy (s1_busy),
		.out_ch  (out_ch)
	);

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane1_res.done == lane2_res.done && lane1_res.busy == lane2_res.busy)
		else $error("pedal lanes out of step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> lane1_res.busy && lane2_res.busy)
		else $error("accepted item did not start the lanes");

	a_done_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		lane1_res.done |-> !s1_busy)
		else $error("lane result arrived while merge stage occupied");

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.stop_flag |=> !out_ch.valid || out_ch.stop_flag)
		else $error("stop flag cleared without reset");

	a_percent_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.pedal1_percent <= PCT_FULL && out_ch.pedal2_percent <= PCT_FULL)
		else $error("travel percent above full scale");

endmodule

// ===== sim/tb_dual_pedal_plausibility_torque.sv =====
`timescale 1ns / 1ps
// Self-checking bench for dual_pedal_plausibility_torque: directed and randomized pedal items,
// register writes between phases, and an in-bench torque predictor checked on every result.
// Depends on dppt_pkg and the channel interfaces in dppt_ifs.
module tb_dual_pedal_plausibility_torque;
	import dppt_pkg::*;

	localparam int BLOCK_LATENCY = 22;
	localparam int MAX_GAP       = 11;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_REPORTS   = 10;
	localparam int TORQUE_FULL   = 60;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 130;
	localparam int SAT_ITEMS     = 270;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;
	localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX      = 12'hFFF;

	typedef struct packed {
		logic [PCT_W-1:0]    pedal1_percent;
		logic [PCT_W-1:0]    pedal2_percent;
		logic [TORQUE_W-1:0] torque_value;
		logic [PCT_W-1:0]    torque_percent;
		logic [MOTOR_W-1:0]  motor_command;
		logic [COUNT_W-1:0]  range_error_count;
		logic [COUNT_W-1:0]  mismatch_count;
		logic                stop_flag;
	} torque_result_t;

	logic clk = 1'b0;
	logic arst_n;

	dppt_in_if  in_ch();
	dppt_out_if out_ch();
	dppt_cfg_if cfg_ch();

	dual_pedal_plausibility_torque dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state and register copy
	lane_cfg_t          lane_set [2];
	logic [COUNT_W-1:0] range_run;
	logic [COUNT_W-1:0] mismatch_run;
	logic               stop_held;

	torque_result_t torque_expected [$];
	int             fail_count = 0;
	bit             no_idle    = 1'b0;
	int             hold_len   = 0;

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
		case (idx)
			REG_P1_UPPER: lane_set[0].upper = val;
			REG_P1_LOWER: lane_set[0].lower = val;
			REG_P2_UPPER: lane_set[1].upper = val;
			REG_P2_LOWER: lane_set[1].lower = val;
			REG_P1_START: lane_set[0].start = val;
			REG_P1_SPAN:  lane_set[0].span  = val;
			REG_P2_START: lane_set[1].start = val;
			REG_P2_SPAN:  lane_set[1].span  = val;
			default: ;
		endcase
	endfunction

	function automatic int unsigned travel_of(logic [SAMPLE_W-1:0] s, lane_cfg_t c);
		int unsigned q;
		if (s < c.start)
			return 0;
		if (c.span == '0)
			return 32'(PCT_FULL);
		q = (32'(s) - 32'(c.start)) * int'(PCT_FULL) / 32'(c.span);
		return (q > 32'(PCT_FULL)) ? 32'(PCT_FULL) : q;
	endfunction

	function automatic torque_result_t predict_torque(logic [SAMPLE_W-1:0] s1, s2);
		torque_result_t r;
		logic bad;
		int unsigned p1, p2, spread, tq;
		bad = (s1 > lane_set[0].upper) || (s1 < lane_set[0].lower) ||
			(s2 > lane_set[1].upper) || (s2 < lane_set[1].lower);
		if (!bad)
			range_run = '0;
		else if (range_run != COUNT_MAX)
			range_run++;
		p1 = travel_of(s1, lane_set[0]);
		p2 = travel_of(s2, lane_set[1]);
		spread = (p1 >= p2) ? p1 - p2 : p2 - p1;
		if (spread <= MISMATCH_LIMIT)
			mismatch_run = '0;
		else if (mismatch_run != COUNT_MAX)
			mismatch_run++;
		tq = ((p1 + p2) / 2) * TORQUE_FULL / int'(PCT_FULL);
		if (range_run >= STOP_LIMIT || mismatch_run >= STOP_LIMIT)
			stop_held = 1'b1;
		r.pedal1_percent    = PCT_W'(p1);
		r.pedal2_percent    = PCT_W'(p2);
		r.torque_value      = TORQUE_W'(tq);
		r.torque_percent    = PCT_W'(tq * int'(PCT_FULL) / TORQUE_FULL);
		r.motor_command     = MOTOR_W'(tq * MOTOR_MUL);
		r.range_error_count = range_run;
		r.mismatch_count    = mismatch_run;
		r.stop_flag         = stop_held;
		return r;
	endfunction

	function automatic string result_text(torque_result_t r);
		return $sformatf("p1 %0d p2 %0d torque %0d tpct %0d motor %0d range %0d mism %0d stop %0d",
			r.pedal1_percent, r.pedal2_percent, r.torque_value, r.torque_percent,
			r.motor_command, r.range_error_count, r.mismatch_count, r.stop_flag);
	endfunction

	// sample helpers that follow the current register copy
	function automatic logic [SAMPLE_W-1:0] pick_inside(int lane);
		lane_cfg_t c;
		c = lane_set[lane];
		if (c.lower > c.upper)
			return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
		return SAMPLE_W'($urandom_range(c.lower, c.upper));
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_outside(int lane);
		lane_cfg_t c;
		c = lane_set[lane];
		if (c.lower > c.upper || (c.lower == '0 && c.upper == SAMPLE_MAX))
			return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
		if (c.upper == SAMPLE_MAX || (c.lower != '0 && $urandom_range(0, 1) == 1))
			return SAMPLE_W'($urandom_range(0, int'(c.lower) - 1));
		return SAMPLE_W'($urandom_range(int'(c.upper) + 1, SAMPLE_MAX));
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_travel(int lane, bit high);
		int st, sp, v;
		st = int'(lane_set[lane].start);
		sp = int'(lane_set[lane].span);
		if (high)
			v = st + sp - int'($urandom_range(0, sp / 8));
		else
			v = st + int'($urandom_range(0, sp / 8));
		if (v > int'(SAMPLE_MAX))
			v = int'(SAMPLE_MAX);
		return SAMPLE_W'(v);
	endfunction

	// sensor two sample at about the same travel as s1 on sensor one
	function automatic logic [SAMPLE_W-1:0] follow_travel(logic [SAMPLE_W-1:0] s1);
		int d, v;
		d = int'(s1) - int'(lane_set[0].start);
		if (d < 0)
			return lane_set[1].start;
		v = int'(lane_set[1].start) + int'($urandom_range(0, 6)) - 3;
		if (lane_set[0].span != '0)
			v += d * int'(lane_set[1].span) / int'(lane_set[0].span);
		if (v < 0)
			v = 0;
		if (v > int'(SAMPLE_MAX))
			v = int'(SAMPLE_MAX);
		return SAMPLE_W'(v);
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] s1, s2);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid         <= 1'b1;
		in_ch.pedal1_sample <= s1;
		in_ch.pedal2_sample <= s2;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		torque_expected.push_back(predict_torque(s1, s2));
	endtask

	// drop the input and wait until the block has drained
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (torque_expected.size() != 0) @(posedge clk);
		repeat (BLOCK_LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
		settle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic write_lane(input int lane, input logic [SAMPLE_W-1:0] upper, lower, start,
		span);
		if (lane == 0) begin
			write_reg(REG_P1_UPPER, upper);
			write_reg(REG_P1_LOWER, lower);
			write_reg(REG_P1_START, start);
			write_reg(REG_P1_SPAN, span);
		end else begin
			write_reg(REG_P2_UPPER, upper);
			write_reg(REG_P2_LOWER, lower);
			write_reg(REG_P2_START, start);
			write_reg(REG_P2_SPAN, span);
		end
	endtask

	task automatic write_random_lane(input int lane);
		int st, sp, lo, hi;
		st = $urandom_range(0, 1500);
		sp = $urandom_range(1, 2500);
		lo = st - int'($urandom_range(0, 100));
		if (lo < 0)
			lo = 0;
		hi = st + sp + int'($urandom_range(0, 100));
		if (hi > int'(SAMPLE_MAX))
			hi = int'(SAMPLE_MAX);
		write_lane(lane, SAMPLE_W'(hi), SAMPLE_W'(lo), SAMPLE_W'(st), SAMPLE_W'(sp));
	endtask

	task automatic test_reset_defaults();
		send_sample(12'd0, 12'd0);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(SAMPLE_MAX, 12'd0);
		send_sample(12'd0, SAMPLE_MAX);
		send_sample(12'd2048, 12'd2048);
		send_sample(12'hAAA, 12'h555);
	endtask

	task automatic test_window_limits();
		write_lane(0, 12'd3000, 12'd100, 12'd0, SAMPLE_MAX);
		write_lane(1, 12'd3500, 12'd200, 12'd0, SAMPLE_MAX);
		send_sample(12'd100, 12'd200);
		send_sample(12'd3000, 12'd3500);
		send_sample(12'd99, 12'd200);
		send_sample(12'd3001, 12'd3500);
		send_sample(12'd100, 12'd199);
		send_sample(12'd100, 12'd3501);
		// inverted window: every sample of sensor two is out of range
		write_reg(REG_P2_LOWER, 12'd3500);
		write_reg(REG_P2_UPPER, 12'd200);
		send_sample(12'd2000, 12'd2000);
		write_lane(0, 12'd0, 12'd0, 12'd0, SAMPLE_MAX);
		write_lane(1, 12'd0, 12'd0, 12'd0, SAMPLE_MAX);
		send_sample(12'd0, 12'd0);
		send_sample(12'd1, 12'd0);
		write_lane(0, SAMPLE_MAX, SAMPLE_MAX, 12'd0, SAMPLE_MAX);
		send_sample(SAMPLE_MAX, 12'd0);
	endtask

	task automatic test_travel_limits();
		write_lane(0, SAMPLE_MAX, 12'd0, SAMPLE_MAX, 12'd1);
		write_lane(1, SAMPLE_MAX, 12'd0, 12'd1000, 12'd1);
		send_sample(SAMPLE_MAX, 12'd1000);
		send_sample(12'd4094, 12'd1001);
		// zero span: full travel at or above start
		write_reg(REG_P2_SPAN, 12'd0);
		write_reg(REG_P2_START, 12'd0);
		send_sample(SAMPLE_MAX, 12'd0);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
	endtask

	task automatic test_spare_index();
		write_lane(0, SAMPLE_MAX, 12'd0, 12'd0, SAMPLE_MAX);
		write_lane(1, SAMPLE_MAX, 12'd0, 12'd0, SAMPLE_MAX);
		write_reg(REG_SPARE_FIRST, 12'd0);
		write_reg(REG_SPARE_LAST, SAMPLE_MAX);
		send_sample(12'h555, 12'hAAA);
		send_sample(12'd2048, 12'd2048);
	endtask

	task automatic test_count_saturation();
		// inverted sensor one window: run the range count into saturation
		write_reg(REG_P1_LOWER, SAMPLE_MAX);
		write_reg(REG_P1_UPPER, 12'd0);
		repeat (SAT_ITEMS)
			send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
				SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
		write_lane(0, SAMPLE_MAX, 12'd0, 12'd0, SAMPLE_MAX);
		repeat (SAT_ITEMS)
			send_sample(pick_travel(0, 1'b1), pick_travel(1, 1'b0));
		send_sample(12'd2048, 12'd2048);
	endtask

	task automatic test_random_runs();
		int sent, kind, run, which;
		logic [SAMPLE_W-1:0] s1, s2;
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				write_lane(0, SAMPLE_MAX, 12'd0, 12'd0, SAMPLE_MAX);
				write_lane(1, SAMPLE_MAX, 12'd0, 12'd0, SAMPLE_MAX);
			end else if (phase == 1) begin
				write_lane(0, SAMPLE_MAX, 12'd0, SAMPLE_W'($urandom_range(0, 4000)), 12'd1);
				write_lane(1, SAMPLE_MAX, 12'd0, SAMPLE_W'($urandom_range(0, 4000)), 12'd1);
			end else begin
				write_random_lane(0);
				write_random_lane(1);
			end
			no_idle = (phase % 4 == 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				kind = $urandom_range(0, 9);
				run = (kind >= 4 && kind <= 7) ? $urandom_range(15, 30) :
					(kind == 8) ? $urandom_range(1, 10) : $urandom_range(1, 25);
				repeat (run) begin
					if (kind == 4 || kind == 5) begin
						which = $urandom_range(0, 2);
						s1 = (which != 1) ? pick_outside(0) : pick_inside(0);
						s2 = (which != 0) ? pick_outside(1) : pick_inside(1);
					end else if (kind == 6 || kind == 7) begin
						which = $urandom_range(0, 1);
						s1 = pick_travel(0, which == 0);
						s2 = pick_travel(1, which == 1);
					end else if (kind == 8) begin
						s1 = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
						s2 = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
					end else begin
						s1 = pick_inside(0);
						s2 = follow_travel(s1);
					end
					send_sample(s1, s2);
					sent++;
				end
			end
			no_idle = 1'b0;
		end
	endtask

	task automatic test_output_backpressure();
		logic [SAMPLE_W-1:0] s1;
		settle();
		hold_len = HOLD_CYCLES;
		no_idle = 1'b1;
		repeat (40) begin
			s1 = pick_inside(0);
			send_sample(s1, follow_travel(s1));
		end
		no_idle = 1'b0;
		settle();
	endtask

	initial begin : result_sink
		torque_result_t got, want;
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end
			if (stall > 0) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			got.pedal1_percent    = out_ch.pedal1_percent;
			got.pedal2_percent    = out_ch.pedal2_percent;
			got.torque_value      = out_ch.torque_value;
			got.torque_percent    = out_ch.torque_percent;
			got.motor_command     = out_ch.motor_command;
			got.range_error_count = out_ch.range_error_count;
			got.mismatch_count    = out_ch.mismatch_count;
			got.stop_flag         = out_ch.stop_flag;
			if (torque_expected.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result: %s", result_text(got));
			end else begin
				want = torque_expected.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("result mismatch: expected %s / got %s",
							result_text(want), result_text(got));
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		in_ch.valid         = 1'b0;
		in_ch.pedal1_sample = '0;
		in_ch.pedal2_sample = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		arst_n              = 1'b0;
		lane_set[0]  = '{upper: SAMPLE_MAX, lower: 12'd0, start: 12'd0, span: SAMPLE_MAX};
		lane_set[1]  = lane_set[0];
		range_run    = '0;
		mismatch_run = '0;
		stop_held    = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_window_limits();
		test_travel_limits();
		test_spare_index();
		test_count_saturation();
		test_random_runs();
		test_output_backpressure();

		settle();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/dppt_pkg.sv
rtl/dppt_ifs.sv
rtl/dppt_lane.sv
rtl/dppt_merge.sv
rtl/dual_pedal_plausibility_torque.sv
sim/tb_dual_pedal_plausibility_torque.sv
